[hw/rtl/prqs_pkg.sv]
// ----------------------------------------------------------------------------
// prqs_pkg
// types, codes and defaults shared by the ready-queue scheduler
// ----------------------------------------------------------------------------
package prqs_pkg;

  localparam int unsigned NUM_TASKS_DEF  = 16;
  localparam int unsigned NUM_LEVELS_DEF = 32;
  localparam logic [15:0] TICK_RESET     = 16'd1;

  typedef enum logic [1:0] {
    CMD_TICK   = 2'd0,
    CMD_SWITCH = 2'd1,
    CMD_READY  = 2'd2,
    CMD_SLEEP  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    MODE_DORMANT  = 2'd0,
    MODE_READY    = 2'd1,
    MODE_RUNNING  = 2'd2,
    MODE_SLEEPING = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TICK,
    ST_TICK_ENQ,
    ST_SW_REQ,
    ST_SW_POP,
    ST_READY,
    ST_SLEEP,
    ST_DONE
  } state_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_TICK_CHK,
    OP_TICK_ENQ,
    OP_SW_REQ,
    OP_SW_POP,
    OP_MAKE_READY,
    OP_SLEEP,
    OP_EMIT
  } op_e;

  typedef struct packed {
    logic [1:0]  command;
    logic [3:0]  task_id;
    logic [4:0]  priority_req;
    logic [31:0] sleep_time;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  cur_task;
    logic        idle;
    logic [4:0]  woken_count;
    logic [31:0] ready_set;
    logic        rejected;
  } out_item_t;

  typedef struct packed {
    op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic walk_nil;
    logic wake;
  } dp_status_t;

endpackage

[hw/rtl/prqs_ctrl.sv]
// ----------------------------------------------------------------------------
// prqs_ctrl
// command sequencer and handshake control of the scheduler
// ----------------------------------------------------------------------------
module prqs_ctrl import prqs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [1:0] in_cmd_i,
  output logic       in_stall_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   emit;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          case (cmd_e'(in_cmd_i))
            CMD_TICK:   state_d = ST_TICK;
            CMD_SWITCH: state_d = ST_SW_REQ;
            CMD_READY:  state_d = ST_READY;
            CMD_SLEEP:  state_d = ST_SLEEP;
            default:    state_d = ST_IDLE;
          endcase
        end
      end
      ST_TICK: begin
        if (status_i.walk_nil) begin
          state_d = ST_DONE;
        end else if (status_i.wake) begin
          state_d = ST_TICK_ENQ;
        end
      end
      ST_TICK_ENQ: state_d = ST_TICK;
      ST_SW_REQ:   state_d = ST_SW_POP;
      ST_SW_POP:   state_d = ST_DONE;
      ST_READY:    state_d = ST_DONE;
      ST_SLEEP:    state_d = ST_DONE;
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o.op = OP_NONE;
    emit     = 1'b0;
    case (state_q)
      ST_IDLE:     if (in_valid_i) cmd_o.op = OP_LOAD;
      ST_TICK:     if (!status_i.walk_nil) cmd_o.op = OP_TICK_CHK;
      ST_TICK_ENQ: cmd_o.op = OP_TICK_ENQ;
      ST_SW_REQ:   cmd_o.op = OP_SW_REQ;
      ST_SW_POP:   cmd_o.op = OP_SW_POP;
      ST_READY:    cmd_o.op = OP_MAKE_READY;
      ST_SLEEP:    cmd_o.op = OP_SLEEP;
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.op = OP_EMIT;
          emit     = 1'b1;
        end
      end
      default: cmd_o.op = OP_NONE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

[hw/rtl/prqs_dp.sv]
// ----------------------------------------------------------------------------
// prqs_dp
// queue, link and sleep list storage with one list update per cycle
// ----------------------------------------------------------------------------
module prqs_dp import prqs_pkg::*; #(
  parameter int unsigned NumTasks  = NUM_TASKS_DEF,
  parameter int unsigned NumLevels = NUM_LEVELS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  dp_cmd_t     cmd_i,
  output dp_status_t  status_o,
  input  in_item_t    in_data_i,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_data_i,
  output out_item_t   out_data_o
);

  localparam int unsigned TaskW  = (NumTasks > 1) ? $clog2(NumTasks) : 1;
  localparam int unsigned LevelW = (NumLevels > 1) ? $clog2(NumLevels) : 1;
  localparam int unsigned PtrW   = TaskW + 1;
  localparam logic [PtrW-1:0] Nil = {1'b1, {TaskW{1'b0}}};

  typedef logic [PtrW-1:0]   ptr_t;
  typedef logic [TaskW-1:0]  tid_t;
  typedef logic [LevelW-1:0] lvl_t;

  logic [NumLevels-1:0] ready_q, ready_d;
  ptr_t  qhead_q [NumLevels];
  ptr_t  qhead_d [NumLevels];
  ptr_t  qtail_q [NumLevels];
  ptr_t  qtail_d [NumLevels];
  ptr_t  lnext_q [NumTasks];
  ptr_t  lnext_d [NumTasks];
  ptr_t  lprev_q [NumTasks];
  ptr_t  lprev_d [NumTasks];
  mode_e mode_q  [NumTasks];
  mode_e mode_d  [NumTasks];
  lvl_t  level_q [NumTasks];
  lvl_t  level_d [NumTasks];
  logic [31:0] tleft_q [NumTasks];
  logic [31:0] tleft_d [NumTasks];
  ptr_t  shead_q, shead_d, stail_q, stail_d;
  ptr_t  run_q, run_d, walk_q, walk_d, nxt_q, nxt_d;
  logic [4:0]  woken_q, woken_d;
  logic        rej_q, rej_d;
  logic [15:0] tick_q;
  in_item_t    in_q;
  out_item_t   out_q;

  tid_t walk_t, run_t, in_t, enq_t, pop_t, p_t, n_t;
  lvl_t enq_lv, top_lv, in_lv;
  ptr_t tail_ptr, pop_n, rp, rn;
  logic enq_en, any_ready, wake;

  assign walk_t = walk_q[TaskW-1:0];
  assign run_t  = run_q[TaskW-1:0];
  assign in_t   = TaskW'(in_q.task_id);
  assign in_lv  = (32'(in_q.priority_req) >= 32'(NumLevels)) ? lvl_t'(NumLevels - 1)
                                                             : lvl_t'(in_q.priority_req);
  assign wake   = (tleft_q[walk_t] <= 32'(tick_q));

  always_comb begin
    top_lv    = '0;
    any_ready = 1'b0;
    for (int i = 0; i < NumLevels; i++) begin
      if (ready_q[i]) begin
        top_lv    = lvl_t'(i);
        any_ready = 1'b1;
      end
    end
  end

  always_comb begin
    ready_d = ready_q;
    qhead_d = qhead_q;
    qtail_d = qtail_q;
    lnext_d = lnext_q;
    lprev_d = lprev_q;
    mode_d  = mode_q;
    level_d = level_q;
    tleft_d = tleft_q;
    shead_d = shead_q;
    stail_d = stail_q;
    run_d   = run_q;
    walk_d  = walk_q;
    nxt_d   = nxt_q;
    woken_d = woken_q;
    rej_d   = rej_q;
    enq_en  = 1'b0;
    enq_t   = walk_t;
    enq_lv  = level_q[walk_t];
    pop_t   = qhead_q[top_lv][TaskW-1:0];
    pop_n   = lnext_q[pop_t];
    rp      = lprev_q[walk_t];
    rn      = lnext_q[walk_t];
    p_t     = rp[TaskW-1:0];
    n_t     = rn[TaskW-1:0];
    case (cmd_i.op)
      OP_LOAD: begin
        woken_d = '0;
        rej_d   = 1'b0;
        walk_d  = shead_q;
      end
      OP_TICK_CHK: begin
        nxt_d = rn;
        if (wake) begin
          tleft_d[walk_t] = '0;
          if (!rp[TaskW]) lnext_d[p_t] = rn;
          else            shead_d      = rn;
          if (!rn[TaskW]) lprev_d[n_t] = rp;
          else            stail_d      = rp;
          lnext_d[walk_t] = Nil;
          lprev_d[walk_t] = Nil;
          woken_d         = woken_q + 5'd1;
        end else begin
          tleft_d[walk_t] = tleft_q[walk_t] - 32'(tick_q);
          walk_d          = rn;
        end
      end
      OP_TICK_ENQ: begin
        enq_en = 1'b1;
        walk_d = nxt_q;
      end
      OP_SW_REQ: begin
        if (!run_q[TaskW] && mode_q[run_t] == MODE_RUNNING) begin
          enq_en = 1'b1;
          enq_t  = run_t;
          enq_lv = level_q[run_t];
        end
      end
      OP_SW_POP: begin
        run_d = Nil;
        if (any_ready) begin
          qhead_d[top_lv] = pop_n;
          if (pop_n[TaskW]) begin
            qtail_d[top_lv] = Nil;
            ready_d[top_lv] = 1'b0;
          end else begin
            lprev_d[pop_n[TaskW-1:0]] = Nil;
          end
          lnext_d[pop_t] = Nil;
          lprev_d[pop_t] = Nil;
          mode_d[pop_t]  = MODE_RUNNING;
          run_d          = {1'b0, pop_t};
        end
      end
      OP_MAKE_READY: begin
        if (32'(in_q.task_id) >= 32'(NumTasks) || mode_q[in_t] == MODE_READY ||
            mode_q[in_t] == MODE_SLEEPING) begin
          rej_d = 1'b1;
        end else begin
          level_d[in_t] = in_lv;
          enq_en        = 1'b1;
          enq_t         = in_t;
          enq_lv        = in_lv;
        end
      end
      OP_SLEEP: begin
        if (run_q[TaskW] || mode_q[run_t] != MODE_RUNNING) begin
          rej_d = 1'b1;
        end else begin
          mode_d[run_t]  = MODE_SLEEPING;
          tleft_d[run_t] = in_q.sleep_time;
          lnext_d[run_t] = Nil;
          lprev_d[run_t] = stail_q;
          if (stail_q[TaskW]) shead_d = run_q;
          else                lnext_d[stail_q[TaskW-1:0]] = run_q;
          stail_d = run_q;
        end
      end
      default: begin
      end
    endcase
    tail_ptr = qtail_q[enq_lv];
    if (enq_en) begin
      ready_d[enq_lv] = 1'b1;
      lnext_d[enq_t]  = Nil;
      lprev_d[enq_t]  = tail_ptr;
      if (tail_ptr[TaskW]) qhead_d[enq_lv] = {1'b0, enq_t};
      else                 lnext_d[tail_ptr[TaskW-1:0]] = {1'b0, enq_t};
      qtail_d[enq_lv] = {1'b0, enq_t};
      mode_d[enq_t]   = MODE_READY;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ready_q <= '0;
      shead_q <= Nil;
      stail_q <= Nil;
      run_q   <= Nil;
      walk_q  <= Nil;
      nxt_q   <= Nil;
      woken_q <= '0;
      rej_q   <= 1'b0;
      tick_q  <= TICK_RESET;
      for (int i = 0; i < NumLevels; i++) begin
        qhead_q[i] <= Nil;
        qtail_q[i] <= Nil;
      end
      for (int i = 0; i < NumTasks; i++) begin
        lnext_q[i] <= Nil;
        lprev_q[i] <= Nil;
        mode_q[i]  <= MODE_DORMANT;
      end
    end else begin
      ready_q <= ready_d;
      qhead_q <= qhead_d;
      qtail_q <= qtail_d;
      lnext_q <= lnext_d;
      lprev_q <= lprev_d;
      mode_q  <= mode_d;
      shead_q <= shead_d;
      stail_q <= stail_d;
      run_q   <= run_d;
      walk_q  <= walk_d;
      nxt_q   <= nxt_d;
      woken_q <= woken_d;
      rej_q   <= rej_d;
      if (cfg_we_i) tick_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    level_q <= level_d;
    tleft_q <= tleft_d;
    if (cmd_i.op == OP_LOAD) in_q <= in_data_i;
    if (cmd_i.op == OP_EMIT) begin
      out_q.cur_task    <= run_q[TaskW] ? 4'd0 : 4'(run_t);
      out_q.idle        <= run_q[TaskW];
      out_q.woken_count <= woken_q;
      out_q.ready_set   <= 32'(ready_q);
      out_q.rejected    <= rej_q;
    end
  end

  assign status_o.walk_nil = walk_q[TaskW];
  assign status_o.wake     = wake;
  assign out_data_o        = out_q;

endmodule

[hw/rtl/priority_ready_queue_scheduler_unit.sv]
// ----------------------------------------------------------------------------
// priority_ready_queue_scheduler_unit
// task scheduler with per-priority fifo ready queues and a sleep list
// ----------------------------------------------------------------------------
// throughput: one command at a time; a tick walks one sleeper per cycle, but
// each woken task also passes through the ST_TICK_ENQ state to be queued
// reset: all queues and the sleep list empty, no task running, tick period 1
module priority_ready_queue_scheduler_unit import prqs_pkg::*; #(
  parameter int unsigned NumTasks  = NUM_TASKS_DEF,
  parameter int unsigned NumLevels = NUM_LEVELS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_item_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_item_t   out_data_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i
);

  dp_cmd_t    dp_cmd;
  dp_status_t dp_status;

  assign cfg_ready_o = 1'b1;

  prqs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_cmd_i    (in_data_i.command),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (dp_status),
    .cmd_o       (dp_cmd)
  );

  prqs_dp #(
    .NumTasks  (NumTasks),
    .NumLevels (NumLevels)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (dp_cmd),
    .status_o   (dp_status),
    .in_data_i  (in_data_i),
    .cfg_we_i   (cfg_valid_i & cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .out_data_o (out_data_o)
  );

endmodule
